// ===== design/deadline_min_queue_core_defines.svh =====
// Assertion macros used by the checker file dmq_checker.sv.
`ifndef DEADLINE_MIN_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_MIN_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DMQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dmq check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DMQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dmq check failed");

`endif

// ===== design/dmq_pkg.sv =====
`timescale 1ns / 1ps
package dmq_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 6;
    localparam int KEY_W = 64;
    localparam int TAG_W = 64;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_PEEK = 2'd1,
        OP_POP  = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [KEY_W-1:0] deadline;
        logic [TAG_W-1:0] cookie;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             take;
        logic             first;
        logic [IDX_W-1:0] slot;
    } t_min_ctl;

    function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCC_W-1:0] ext;
        ext = {{OCC_W{1'b0}}, cnt};
        return ext[OCC_W-1:0];
    endfunction

endpackage

// ===== design/dmq_ram.sv =====
`timescale 1ns / 1ps
module dmq_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dmq_min_unit.sv =====
`timescale 1ns / 1ps
module dmq_min_unit import dmq_pkg::*; (
    input  logic             i_clk,
    input  t_min_ctl         i_ctl,
    input  t_entry           i_entry,
    output t_entry           o_best,
    output logic [IDX_W-1:0] o_best_slot
);

    t_entry           r_best;
    logic [IDX_W-1:0] r_best_slot;
    logic             w_take;

    // strict compare: earlier slot keeps ties
    assign w_take = i_ctl.take && (i_ctl.first || (i_entry.deadline < r_best.deadline));

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best      <= i_entry;
            r_best_slot <= i_ctl.slot;
        end
    end

    assign o_best      = r_best;
    assign o_best_slot = r_best_slot;

endmodule

// ===== design/deadline_min_queue_core.sv =====
`timescale 1ns / 1ps
// Earliest-deadline queue of up to DEPTH entries (deadline plus cookie).
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; i_opcode selects push, peek or pop, i_deadline_in and
// i_cookie_in carry the entry to push.
// Result channel: o_valid is high for exactly one cycle with o_ok,
// o_deadline_out, o_cookie_out and o_occupancy; the receiver cannot stall,
// so the result must be captured in that cycle.
// Push, unused opcodes and peek or pop on an empty queue answer in the cycle
// after acceptance, and busy stays low: one such transaction per cycle.
// Peek and pop scan every stored entry through one comparator and a single
// entry RAM with registered read; for peek, busy falls when the result
// appears. Pop then also moves the last entry into the freed slot through
// S_MOVE_RD and S_MOVE_WR, unless the earliest entry sat in the last slot;
// busy stays high until that write is done.
// Reset (i_rst_n low, synchronous) empties the queue and drops any
// transaction in progress; entry RAM contents are not cleared.
module deadline_min_queue_core import dmq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_opcode,
    input  logic [KEY_W-1:0] i_deadline_in,
    input  logic [TAG_W-1:0] i_cookie_in,
    output logic             o_valid,
    output logic             o_ok,
    output logic [KEY_W-1:0] o_deadline_out,
    output logic [TAG_W-1:0] o_cookie_out,
    output logic [OCC_W-1:0] o_occupancy
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SCAN    = 4'b0010,
        S_MOVE_RD = 4'b0100,
        S_MOVE_WR = 4'b1000
    } t_state;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_pend, n_pend;
    logic             r_pend_first, n_pend_first;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic             r_pop, n_pop;

    logic             r_o_valid, n_o_valid;
    logic             r_o_ok, n_o_ok;
    logic [KEY_W-1:0] r_o_dl, n_o_dl;
    logic [TAG_W-1:0] r_o_ck, n_o_ck;
    logic [OCC_W-1:0] r_o_occ, n_o_occ;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_entry           w_wdata;
    logic [IDX_W-1:0] w_raddr;
    t_entry           w_rdata;
    t_entry           w_best;
    logic [IDX_W-1:0] w_best_slot;
    t_min_ctl         w_min_ctl;

    dmq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_min_ctl.take  = r_pend;
    assign w_min_ctl.first = r_pend_first;
    assign w_min_ctl.slot  = r_pend_idx;

    dmq_min_unit u_min (
        .i_clk       (i_clk),
        .i_ctl       (w_min_ctl),
        .i_entry     (w_rdata),
        .o_best      (w_best),
        .o_best_slot (w_best_slot)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_pend       = 1'b0;
        n_pend_first = r_pend_first;
        n_pend_idx   = r_pend_idx;
        n_pop        = r_pop;
        n_o_valid    = 1'b0;
        n_o_ok       = 1'b0;
        n_o_dl       = '0;
        n_o_ck       = '0;
        n_o_occ      = r_o_occ;
        w_we         = 1'b0;
        w_waddr      = r_count[IDX_W-1:0];
        w_wdata      = '{deadline: i_deadline_in, cookie: i_cookie_in};
        w_raddr      = r_rd_idx[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_opcode'(i_opcode))
                        OP_PUSH: begin
                            n_o_valid = 1'b1;
                            if (r_count < FULL_CNT) begin
                                w_we    = 1'b1;
                                n_count = CNT_W'(r_count + 1'b1);
                                n_o_ok  = 1'b1;
                            end
                            n_o_occ = occ_of(n_count);
                        end
                        OP_PEEK, OP_POP: begin
                            if (r_count == '0) begin
                                n_o_valid = 1'b1;
                                n_o_occ   = occ_of(r_count);
                            end else begin
                                n_state  = S_SCAN;
                                n_rd_idx = '0;
                                n_pop    = (t_opcode'(i_opcode) == OP_POP);
                            end
                        end
                        default: begin
                            n_o_valid = 1'b1;
                            n_o_occ   = occ_of(r_count);
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rd_idx < r_count) begin
                    n_pend       = 1'b1;
                    n_pend_first = (r_rd_idx == '0);
                    n_pend_idx   = r_rd_idx[IDX_W-1:0];
                    n_rd_idx     = CNT_W'(r_rd_idx + 1'b1);
                end else if (!r_pend) begin
                    n_o_valid = 1'b1;
                    n_o_ok    = 1'b1;
                    n_o_dl    = w_best.deadline;
                    n_o_ck    = w_best.cookie;
                    n_state   = S_IDLE;
                    if (r_pop) begin
                        n_count = CNT_W'(r_count - 1'b1);
                        if (CNT_W'(w_best_slot) != n_count) begin
                            n_state = S_MOVE_RD;
                        end
                    end
                    n_o_occ = occ_of(n_count);
                end
            end
            S_MOVE_RD: begin
                w_raddr = r_count[IDX_W-1:0];
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                w_we    = 1'b1;
                w_waddr = w_best_slot;
                w_wdata = w_rdata;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_pend_first <= n_pend_first;
        r_pend_idx   <= n_pend_idx;
        r_pop        <= n_pop;
        r_o_ok       <= n_o_ok;
        r_o_dl       <= n_o_dl;
        r_o_ck       <= n_o_ck;
        r_o_occ      <= n_o_occ;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_ok           = r_o_ok;
    assign o_deadline_out = r_o_dl;
    assign o_cookie_out   = r_o_ck;
    assign o_occupancy    = r_o_occ;

endmodule

// ===== design/dmq_checker.sv =====
`timescale 1ns / 1ps
`include "deadline_min_queue_core_defines.svh"
module dmq_checker import dmq_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [1:0]       i_opcode,
    input logic [KEY_W-1:0] i_deadline_in,
    input logic [TAG_W-1:0] i_cookie_in,
    input logic             o_valid,
    input logic             o_ok,
    input logic [KEY_W-1:0] o_deadline_out,
    input logic [TAG_W-1:0] o_cookie_out,
    input logic [OCC_W-1:0] o_occupancy
);

    `DMQ_ASSERT_NXT(a_push_answers_next, start && !busy && (i_opcode == OP_PUSH), o_valid && !busy)
    `DMQ_ASSERT_NXT(a_scan_or_answer, start && !busy && (i_opcode == OP_PEEK || i_opcode == OP_POP), busy || o_valid)
    `DMQ_ASSERT_IMP(a_fail_zero_payload, o_valid && !o_ok, o_deadline_out == '0 && o_cookie_out == '0)
    `DMQ_ASSERT_NXT(a_idle_holds, !busy && !start, !busy && !o_valid)

endmodule

bind deadline_min_queue_core dmq_checker u_dmq_checker (.*);
